/* src/fsc_pkg.sv */
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the frustum box cull
// Register map, matrix layout, box beat and control types for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

    // matrix registers
    localparam int NUM_CFG_REGS = 8;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_SEL_W    = $clog2(NUM_CFG_REGS);
    localparam int DATA_W       = 64;
    localparam int ELEM_W       = 32;
    localparam int COEF_W       = ELEM_W + 1;
    localparam int LAST_ROW     = 3;
    localparam int ROW_REGS     = 2;

    // plane offset scale, Q16.16 to Q32.32
    localparam int D_SHIFT      = 16;

    // planes and box coordinates
    localparam int PLANE_COUNT     = 6;
    localparam int AXES            = 3;
    localparam int CENTER_W        = 32;
    localparam int HALF_W          = 31;
    localparam int COORD_WIDTH_DEF = 32;

    typedef logic [NUM_CFG_REGS-1:0][DATA_W-1:0] t_mat;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [CENTER_W-1:0] center_z;
        logic [HALF_W-1:0]   half_x;
        logic [HALF_W-1:0]   half_y;
        logic [HALF_W-1:0]   half_z;
    } t_box;

    // beat control handed from cell to cell
    typedef struct packed {
        logic valid;
        logic pass;
    } t_ctl;

endpackage

`default_nettype wire

/* src/fsc_cell.sv */
// ----------------------------------------------------------------------------
// fsc_cell: one plane test of the cull chain
// Forms its plane from the matrix, picks the far box corner, multiplies and
// sums over three stages, and hands the box and running pass flag onwards.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_cell #(
    parameter int PLANE       = 0,
    parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire fsc_pkg::t_mat i_mat,
    input  wire fsc_pkg::t_ctl i_ctl,
    input  wire fsc_pkg::t_box i_box,
    output fsc_pkg::t_ctl    o_ctl,
    output fsc_pkg::t_box    o_box
);
    import fsc_pkg::*;

    localparam int ROW      = (PLANE / 2) % LAST_ROW;
    localparam bit MINUS    = (PLANE % 2) != 0;
    localparam int CORNER_W = COORD_WIDTH + 1;
    localparam int PROD_W   = COEF_W + CORNER_W;
    localparam int D_W      = COEF_W + D_SHIFT;
    localparam int SUM_W    = ((PROD_W > D_W) ? PROD_W : D_W) + 2;

    logic signed [COEF_W-1:0]   r_coef [AXES+1];
    logic signed [COEF_W-1:0]   n_coef [AXES+1];

    logic signed [CORNER_W-1:0] w_ctr    [AXES];
    logic signed [CORNER_W-1:0] w_half   [AXES];
    logic signed [CORNER_W-1:0] n_corner [AXES];
    logic signed [CORNER_W-1:0] r_corner [AXES];
    logic signed [PROD_W-1:0]   r_prod   [AXES];
    logic signed [D_W-1:0]      r_d;
    logic signed [SUM_W-1:0]    w_sum;

    logic [CENTER_W-1:0] w_ctr_raw  [AXES];
    logic [HALF_W-1:0]   w_half_raw [AXES];

    t_ctl r_ctl1, r_ctl2, r_ctl3;
    t_box r_box1, r_box2, r_box3;

    // plane coefficients: row 3 plus or minus this cell's row
    for (genvar c = 0; c < AXES + 1; c++) begin : g_coef
        logic signed [ELEM_W-1:0] w_base;
        logic signed [ELEM_W-1:0] w_other;
        assign w_base  = i_mat[ROW_REGS*LAST_ROW + c/2][(c%2)*ELEM_W +: ELEM_W];
        assign w_other = i_mat[ROW_REGS*ROW + c/2][(c%2)*ELEM_W +: ELEM_W];
        assign n_coef[c] = MINUS ? (COEF_W'(w_base) - COEF_W'(w_other))
                                 : (COEF_W'(w_base) + COEF_W'(w_other));
    end

    // coefficients are a registered copy of the planes formed from the matrix
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < AXES + 1; c++) begin
            r_coef[c] <= n_coef[c];
        end
    end

    // box fields by axis, cut to the coordinate width in the corner select below
    assign w_ctr_raw[0]  = i_box.center_x;
    assign w_ctr_raw[1]  = i_box.center_y;
    assign w_ctr_raw[2]  = i_box.center_z;
    assign w_half_raw[0] = i_box.half_x;
    assign w_half_raw[1] = i_box.half_y;
    assign w_half_raw[2] = i_box.half_z;

    // far corner along the plane normal, chosen from the current matrix
    for (genvar c = 0; c < AXES; c++) begin : g_corner
        logic signed [COORD_WIDTH-1:0] w_ctr_cut;
        logic        [COORD_WIDTH-2:0] w_half_cut;
        assign w_ctr_cut   = w_ctr_raw[c][COORD_WIDTH-1:0];
        assign w_half_cut  = w_half_raw[c][COORD_WIDTH-2:0];
        assign w_ctr[c]    = CORNER_W'(w_ctr_cut);
        assign w_half[c]   = signed'(CORNER_W'(w_half_cut));
        assign n_corner[c] = n_coef[c][COEF_W-1] ? (w_ctr[c] - w_half[c])
                                                 : (w_ctr[c] + w_half[c]);
    end

    // plane value, d scaled up to the product format
    assign w_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1]) + SUM_W'(r_prod[2])
                 + SUM_W'(r_d);

    // control of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl1      <= i_ctl;
            r_ctl2      <= r_ctl1;
            r_ctl3.valid <= r_ctl2.valid;
            r_ctl3.pass  <= r_ctl2.pass & ~w_sum[SUM_W-1];
        end
    end

    // payload of the three stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < AXES; c++) begin
                r_corner[c] <= n_corner[c];
                r_prod[c]   <= PROD_W'(r_coef[c]) * PROD_W'(r_corner[c]);
            end
            r_d    <= D_W'(r_coef[AXES]) <<< D_SHIFT;
            r_box1 <= i_box;
            r_box2 <= r_box1;
            r_box3 <= r_box2;
        end
    end

    assign o_ctl = r_ctl3;
    assign o_box = r_box3;

    // a failed plane earlier in the chain can never be undone here
    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !r_ctl2.pass |=> !r_ctl3.pass)
        else $error("pass flag recovered after an earlier plane failed");

    // a box on the non-negative side keeps the flag it arrived with
    a_pass_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_ctl2.pass && !w_sum[SUM_W-1] |=> r_ctl3.pass)
        else $error("pass flag lost on a non-negative plane value");

    // a stalled chain holds its beats
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_ctl1) && $stable(r_ctl2) && $stable(r_ctl3))
        else $error("cell control moved while the chain was stalled");

endmodule

`default_nettype wire

/* src/frustum_box_cull.sv */
// ----------------------------------------------------------------------------
// frustum_box_cull: view frustum test of an axis-aligned box
// Matrix registers feed a chain of six plane cells; each box walks the chain
// and comes out flagged visible only if every plane passes.
// ----------------------------------------------------------------------------
// pipeline: six cells of three stages each (corner select, multiply, sum)
//   from input beat to result beat, the last stage is the output register
// throughput: one box per cycle; a stalled result holds the whole chain
// reset: synchronous, clears the matrix registers to zero and empties the chain
// configuration writes are taken every cycle (ready is tied high)
`default_nettype none

module frustum_box_cull #(
    parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fsc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [fsc_pkg::DATA_W-1:0]      i_cfg_data,
    // box beats
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [fsc_pkg::CENTER_W-1:0]    i_center_x,
    input  wire logic [fsc_pkg::CENTER_W-1:0]    i_center_y,
    input  wire logic [fsc_pkg::CENTER_W-1:0]    i_center_z,
    input  wire logic [fsc_pkg::HALF_W-1:0]      i_half_x,
    input  wire logic [fsc_pkg::HALF_W-1:0]      i_half_y,
    input  wire logic [fsc_pkg::HALF_W-1:0]      i_half_z,
    // result beats
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_visible
);
    import fsc_pkg::*;

    t_mat r_mat;
    logic w_en;
    logic w_cfg_hit;
    t_ctl w_ctl [PLANE_COUNT+1];
    t_box w_box [PLANE_COUNT+1];

    // matrix registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_hit   = i_cfg_valid && (i_cfg_index < CFG_INDEX_W'(NUM_CFG_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (w_cfg_hit) begin
            r_mat[i_cfg_index[CFG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // chain advances unless the result register is full and held
    assign w_en       = !w_ctl[PLANE_COUNT].valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_ctl[0].valid    = i_in_valid && w_en;
    assign w_ctl[0].pass     = 1'b1;
    assign w_box[0].center_x = i_center_x;
    assign w_box[0].center_y = i_center_y;
    assign w_box[0].center_z = i_center_z;
    assign w_box[0].half_x   = i_half_x;
    assign w_box[0].half_y   = i_half_y;
    assign w_box[0].half_z   = i_half_z;

    // one cell per plane
    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
        fsc_cell #(
            .PLANE       (p),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_mat   (r_mat),
            .i_ctl   (w_ctl[p]),
            .i_box   (w_box[p]),
            .o_ctl   (w_ctl[p+1]),
            .o_box   (w_box[p+1])
        );
    end

    assign o_out_valid = w_ctl[PLANE_COUNT].valid;
    assign o_visible   = w_ctl[PLANE_COUNT].pass && (w_box[PLANE_COUNT] == w_box[PLANE_COUNT]);

    // writes beyond the register list leave the matrix alone
    a_cfg_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && !w_cfg_hit |=> $stable(r_mat))
        else $error("matrix changed on an out-of-range write");

    // an in-range write lands in the addressed register
    a_cfg_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> r_mat[$past(i_cfg_index[CFG_SEL_W-1:0])] == $past(i_cfg_data))
        else $error("matrix register not written");

    // reset empties the chain
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: frustum box cull
// Loads a series of view-projection matrices, streams boxes through the cull
// chain under several idling patterns and a long output hold-off, and checks
// every visible flag against a plane-by-plane predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import fsc_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int LATENCY       = 18;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BOXES   = 200;
    localparam int RANDOM_PHASES = 9;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int Q_ONE         = 65536;

    // indexes past the matrix, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_FIRST = CFG_INDEX_W'(NUM_CFG_REGS);
    localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LAST  = '1;

    localparam logic [ELEM_W-1:0] ELEM_ONE = ELEM_W'(Q_ONE);
    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [HALF_W-1:0] HALF_MAX = '1;
    localparam logic [HALF_W-1:0] HALF_ONE = HALF_W'(Q_ONE);

    // clock and reset
    logic i_clk;
    logic i_rst_n = 1'b0;

    // configuration channel
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]      i_cfg_data  = '0;

    // box channel
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CENTER_W-1:0] i_center_x = '0;
    logic [CENTER_W-1:0] i_center_y = '0;
    logic [CENTER_W-1:0] i_center_z = '0;
    logic [HALF_W-1:0]   i_half_x   = '0;
    logic [HALF_W-1:0]   i_half_y   = '0;
    logic [HALF_W-1:0]   i_half_z   = '0;

    // result channel
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_visible;

    // bench state
    t_box  box_backlog[$];
    logic  visible_due[$];
    t_mat  matrix_copy = '0;
    t_box  next_box;
    logic  in_beat_taken = 1'b0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    logic  pressure_on = 1'b0;
    int    hold_count = 0;
    int    fail_count = 0;
    int    cycle_count = 0;
    wire   hold_active = pressure_on && (hold_count < HOLD_CYCLES);

    frustum_box_cull DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_center_z (i_center_z),
        .i_half_x   (i_half_x),
        .i_half_y   (i_half_y),
        .i_half_z   (i_half_z),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_visible  (o_visible)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD/2) i_clk = ~i_clk;
    end

    // matrix element as held in the bench copy, signed Q16.16
    function automatic logic signed [ELEM_W-1:0] matrix_elem(int row, int col);
        logic [DATA_W-1:0] word;
        word = matrix_copy[ROW_REGS*row + col/2];
        return (col % 2 != 0) ? word[DATA_W-1:ELEM_W] : word[ELEM_W-1:0];
    endfunction

    // six planes from row 3 plus and minus rows 0..2, farthest corner per plane
    function automatic logic predict_visible(t_box b);
        logic signed [127:0] ctr [AXES];
        logic signed [127:0] half [AXES];
        logic signed [127:0] coef [4];
        logic signed [127:0] base, other, corner, plane_sum;
        logic vis;
        vis = 1'b1;
        ctr[0]  = $signed(b.center_x);
        ctr[1]  = $signed(b.center_y);
        ctr[2]  = $signed(b.center_z);
        half[0] = b.half_x;
        half[1] = b.half_y;
        half[2] = b.half_z;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int c = 0; c < 4; c++) begin
                base    = matrix_elem(LAST_ROW, c);
                other   = matrix_elem(p / 2, c);
                coef[c] = (p % 2 != 0) ? base - other : base + other;
            end
            // offset is Q16.16, products are Q32.32
            plane_sum = coef[3] <<< D_SHIFT;
            for (int c = 0; c < AXES; c++) begin
                corner    = (coef[c] >= 0) ? ctr[c] + half[c] : ctr[c] - half[c];
                plane_sum = plane_sum + coef[c] * corner;
            end
            if (plane_sum < 0) vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic t_box make_box(logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
                                      logic [CENTER_W-1:0] cz, logic [HALF_W-1:0] hx,
                                      logic [HALF_W-1:0] hy, logic [HALF_W-1:0] hz);
        t_box b;
        b.center_x = cx;
        b.center_y = cy;
        b.center_z = cz;
        b.half_x   = hx;
        b.half_y   = hy;
        b.half_z   = hz;
        return b;
    endfunction

    // mostly boxes near the unit frustum, some mid-range, some raw bits
    function automatic t_box random_box();
        t_box b;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            b.center_x = CENTER_W'($urandom_range(0, 8*Q_ONE)) - CENTER_W'(4*Q_ONE);
            b.center_y = CENTER_W'($urandom_range(0, 8*Q_ONE)) - CENTER_W'(4*Q_ONE);
            b.center_z = CENTER_W'($urandom_range(0, 8*Q_ONE)) - CENTER_W'(4*Q_ONE);
            b.half_x   = HALF_W'($urandom_range(0, 2*Q_ONE));
            b.half_y   = HALF_W'($urandom_range(0, 2*Q_ONE));
            b.half_z   = HALF_W'($urandom_range(0, 2*Q_ONE));
        end else if (kind < 8) begin
            b.center_x = CENTER_W'($urandom_range(0, 1 << 25)) - CENTER_W'(1 << 24);
            b.center_y = CENTER_W'($urandom_range(0, 1 << 25)) - CENTER_W'(1 << 24);
            b.center_z = CENTER_W'($urandom_range(0, 1 << 25)) - CENTER_W'(1 << 24);
            b.half_x   = HALF_W'($urandom_range(0, 1 << 23));
            b.half_y   = HALF_W'($urandom_range(0, 1 << 23));
            b.half_z   = HALF_W'($urandom_range(0, 1 << 23));
        end else begin
            b.center_x = $urandom();
            b.center_y = $urandom();
            b.center_z = $urandom();
            b.half_x   = HALF_W'($urandom());
            b.half_y   = HALF_W'($urandom());
            b.half_z   = HALF_W'($urandom());
        end
        return b;
    endfunction

    function automatic t_mat uniform_matrix(logic [ELEM_W-1:0] v);
        t_mat m;
        for (int r = 0; r < NUM_CFG_REGS; r++) m[r] = {v, v};
        return m;
    endfunction

    function automatic t_mat diag_matrix(logic [ELEM_W-1:0] v);
        t_mat m;
        m = '0;
        for (int i = 0; i <= LAST_ROW; i++) m[ROW_REGS*i + i/2][ELEM_W*(i%2) +: ELEM_W] = v;
        return m;
    endfunction

    function automatic t_mat random_small_matrix(int span);
        t_mat m;
        for (int r = 0; r < NUM_CFG_REGS; r++) begin
            m[r][ELEM_W-1:0]      = ELEM_W'($urandom_range(0, 2*span)) - ELEM_W'(span);
            m[r][DATA_W-1:ELEM_W] = ELEM_W'($urandom_range(0, 2*span)) - ELEM_W'(span);
        end
        return m;
    endfunction

    // normals all zero, only the row 3 offset set
    function automatic t_mat offset_only_matrix(logic [ELEM_W-1:0] d);
        t_mat m;
        m = '0;
        m[ROW_REGS*LAST_ROW + 1][DATA_W-1:ELEM_W] = d;
        return m;
    endfunction

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_matrix(t_mat m);
        for (int r = 0; r < NUM_CFG_REGS; r++) cfg_write(CFG_INDEX_W'(r), m[r]);
    endtask

    // every box sent and every result back
    task automatic wait_idle();
        while (box_backlog.size() != 0 || i_in_valid || visible_due.size() != 0)
            @(negedge i_clk);
    endtask

    // box driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_beat_taken) begin
            if (box_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_box = box_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_center_x <= next_box.center_x;
                i_center_y <= next_box.center_y;
                i_center_z <= next_box.center_z;
                i_half_x   <= next_box.half_x;
                i_half_y   <= next_box.half_y;
                i_half_z   <= next_box.half_z;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long output hold-off, counted on its own
    always @(negedge i_clk) begin
        if (hold_active) hold_count <= hold_count + 1;
    end

    // result receiver
    always @(negedge i_clk) begin
        i_out_ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: mirror config writes, predict on box beats, check result beats
    always @(posedge i_clk) begin
        in_beat_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < NUM_CFG_REGS)
                matrix_copy[i_cfg_index[CFG_SEL_W-1:0]] = i_cfg_data;
            if (i_in_valid && o_in_ready)
                visible_due.push_back(predict_visible(make_box(i_center_x, i_center_y,
                    i_center_z, i_half_x, i_half_y, i_half_z)));
            if (o_out_valid && i_out_ready) begin
                if (visible_due.size() == 0) begin
                    $error("visible: result beat with nothing pending, got %0b", o_visible);
                    fail_count++;
                end else if (o_visible !== visible_due[0]) begin
                    $error("visible: expected %0b, got %0b", visible_due[0], o_visible);
                    fail_count++;
                    void'(visible_due.pop_front());
                end else begin
                    void'(visible_due.pop_front());
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        t_mat m;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset matrix: every plane value is zero, so all visible
        box_backlog.push_back(make_box('0, '0, '0, '0, '0, '0));
        box_backlog.push_back(make_box(ELEM_MIN, ELEM_MAX, ELEM_MIN, HALF_MAX, '0, HALF_MAX));
        wait_idle();

        // zero normals: only the offset sign decides
        load_matrix(offset_only_matrix(-ELEM_ONE));
        box_backlog.push_back(make_box('0, '0, '0, '0, '0, '0));
        box_backlog.push_back(make_box(ELEM_MAX, ELEM_MIN, ELEM_MAX, HALF_MAX, HALF_MAX, '0));
        wait_idle();
        load_matrix(offset_only_matrix(ELEM_ONE));
        box_backlog.push_back(make_box(ELEM_MIN, ELEM_MIN, ELEM_MIN, '0, '0, '0));
        wait_idle();

        // identity: clip cube of half size one, then writes past the matrix
        load_matrix(diag_matrix(ELEM_ONE));
        cfg_write(SPARE_INDEX_FIRST, '1);
        cfg_write(SPARE_INDEX_LAST, '0);
        box_backlog.push_back(make_box('0, '0, '0, '0, '0, '0));
        box_backlog.push_back(make_box(ELEM_ONE/2, ELEM_ONE/2, ELEM_ONE/2,
                                       HALF_ONE/4, HALF_ONE/4, HALF_ONE/4));
        box_backlog.push_back(make_box(3*ELEM_ONE, '0, '0, HALF_ONE, HALF_ONE, HALF_ONE));
        box_backlog.push_back(make_box(-3*ELEM_ONE, '0, '0, HALF_ONE, HALF_ONE, HALF_ONE));
        box_backlog.push_back(make_box('0, 3*ELEM_ONE, '0, HALF_ONE, HALF_ONE, HALF_ONE));
        box_backlog.push_back(make_box('0, -3*ELEM_ONE, '0, HALF_ONE, HALF_ONE, HALF_ONE));
        box_backlog.push_back(make_box('0, '0, 3*ELEM_ONE, HALF_ONE, HALF_ONE, HALF_ONE));
        box_backlog.push_back(make_box('0, '0, -3*ELEM_ONE, HALF_ONE, HALF_ONE, HALF_ONE));
        box_backlog.push_back(make_box(3*ELEM_ONE, '0, '0, 5*HALF_ONE/2, '0, '0));
        // touching a plane passes, one step beyond is culled
        box_backlog.push_back(make_box(ELEM_ONE, '0, '0, '0, '0, '0));
        box_backlog.push_back(make_box(ELEM_ONE + 1, '0, '0, '0, '0, '0));
        box_backlog.push_back(make_box(ELEM_MIN, ELEM_MIN, ELEM_MIN, '0, '0, '0));
        box_backlog.push_back(make_box(ELEM_MAX, ELEM_MAX, ELEM_MAX, HALF_MAX, HALF_MAX, HALF_MAX));
        box_backlog.push_back(make_box(ELEM_MIN, ELEM_MIN, ELEM_MIN, HALF_MAX, HALF_MAX, HALF_MAX));
        box_backlog.push_back(make_box('0, '0, '0, HALF_MAX, HALF_MAX, HALF_MAX));
        box_backlog.push_back(make_box('1, '1, '1, '1, '1, '1));
        wait_idle();

        // random phases over matrix settings and idling patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: m = diag_matrix(ELEM_ONE);
                1: m = random_small_matrix(2*Q_ONE);
                2: begin
                    m = uniform_matrix(ELEM_MAX);
                    m[ROW_REGS*LAST_ROW]     = {ELEM_MIN, ELEM_MIN};
                    m[ROW_REGS*LAST_ROW + 1] = {ELEM_MIN, ELEM_MIN};
                end
                3: for (int r = 0; r < NUM_CFG_REGS; r++) m[r] = {$urandom(), $urandom()};
                4: m = random_small_matrix(Q_ONE);
                5: m = uniform_matrix('1);
                6: m = uniform_matrix(ELEM_MAX);
                7: m = uniform_matrix(ELEM_MIN);
                default: m = random_small_matrix(8*Q_ONE);
            endcase
            load_matrix(m);
            cfg_write(CFG_INDEX_W'($urandom_range(NUM_CFG_REGS, (1 << CFG_INDEX_W) - 1)),
                      {$urandom(), $urandom()});
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            // output held while boxes keep coming, the chain fills and backs up
            if (ph == 4) pressure_on = 1'b1;
            for (int n = 0; n < PHASE_BOXES; n++) box_backlog.push_back(random_box());
            wait_idle();
        end

        repeat (2*LATENCY) @(negedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
